FILE: rtl/array_list_insert_delete_sort_unit_assert.svh
// Assertion macros for the packed list unit.
// Included by the top level; the macros expect clk_i and rst_ni in scope.
`ifndef ARRAY_LIST_INSERT_DELETE_SORT_UNIT_ASSERT_SVH
`define ARRAY_LIST_INSERT_DELETE_SORT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALIDS_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("list unit check failed");

// The consequent must hold in the cycle after the antecedent.
`define ALIDS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("list unit check failed");

`endif

FILE: rtl/alids_pkg.sv
// Shared types and constants of the packed list unit.
// Used by the compare unit, the sequencer and the top level; no dependencies.
`default_nettype none

package alids_pkg;

  localparam int FUNC_W = 4;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int CAP_W = 8;
  localparam int CNT_W = 8;
  localparam int STAT_W = 2;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 48;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;
  localparam logic [VAL_W-1:0] FAIL_WORD = 32'hFFFF_FFFF;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_HEAD = 4'd0,
    FN_INS_TAIL = 4'd1,
    FN_INS_POS  = 4'd2,
    FN_DEL_HEAD = 4'd3,
    FN_DEL_TAIL = 4'd4,
    FN_DEL_POS  = 4'd5,
    FN_RD_IDX   = 4'd6,
    FN_WR_IDX   = 4'd7,
    FN_SORT     = 4'd8
  } alids_func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADPOS = 2'd3
  } alids_status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_SHIFT_END,
    ST_SORT_START,
    ST_SORT_RUN,
    ST_DONE
  } alids_state_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  value;
  } alids_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] data_out;
    alids_status_e    status;
    logic [CNT_W-1:0] count;
  } alids_res_t;

endpackage

`default_nettype wire

FILE: rtl/array_list_insert_delete_sort_unit.sv
// Top level of the packed list unit: stream ports, output register, list RAM.
// Depends on alids_pkg, alids_ctrl, alids_ram and the assertion macro header.
//
// Usage: each transaction on the slave stream carries one request (func, position,
// value); exactly one result (data_out, status, count) leaves on the master stream
// for every request, in order. The capacity register is written through cfg_we_i
// and cfg_wdata_i; the user must write it only while the unit is idle, which the
// unit does not enforce. After reset the list is empty, the capacity is 100, and a
// clearing pass zeroes the RAM before the first request is taken. One request is
// worked at a time through a single RAM with one write and one registered read
// port and one signed compare unit. Writes, refused requests, tail inserts, inserts
// into an empty list and unused codes go from idle straight to the done state;
// reads pass the read state first. An insert or delete moves the words behind its
// position one by one. A sort of n words runs bubble passes over n, then n - 1
// words and so on, and stops after the first pass without a swap. The result waits
// in an output register; the next request is accepted while it waits, and a
// stalled master side holds the unit only once its next result is ready.
`default_nettype none
`include "array_list_insert_delete_sort_unit_assert.svh"

module array_list_insert_delete_sort_unit #(
  parameter int DEPTH = 128
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [alids_pkg::CAP_W-1:0]         cfg_wdata_i,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // func [3:0], position [10:4], value [42:11], zero fill [47:43]
  input  wire logic [alids_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // data_out [31:0], status [33:32], count [41:34], zero fill [47:42]
  output logic      [alids_pkg::M_TDATA_W-1:0]     m_axis_tdata_o
);

  import alids_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int POS_LO = FUNC_W;
  localparam int VAL_LO = FUNC_W + POS_W;
  localparam int STAT_LO = VAL_W;
  localparam int CNT_LO = VAL_W + STAT_W;
  localparam int OUT_BITS = VAL_W + STAT_W + CNT_W;

  alids_item_t      item;
  alids_res_t       res;
  alids_res_t       m_res_q;
  logic             m_valid_q;
  logic             res_valid;
  logic             out_free;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [VAL_W-1:0] ram_rdata;

  assign item.func     = s_axis_tdata_i[POS_LO-1:0];
  assign item.position = s_axis_tdata_i[VAL_LO-1:POS_LO];
  assign item.value    = s_axis_tdata_i[VAL_LO+VAL_W-1:VAL_LO];

  assign out_free = !m_valid_q || m_axis_tready_i;

  alids_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (s_axis_tvalid_i),
    .item_i       (item),
    .item_ready_o (s_axis_tready_o),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  alids_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o[STAT_LO-1:0]          = m_res_q.data_out;
  assign m_axis_tdata_o[CNT_LO-1:STAT_LO]     = m_res_q.status;
  assign m_axis_tdata_o[OUT_BITS-1:CNT_LO]    = m_res_q.count;
  assign m_axis_tdata_o[M_TDATA_W-1:OUT_BITS] = '0;

  `ALIDS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  `ALIDS_ASSERT_NEXT(a_result_held_for_slot, res_valid && !out_free, res_valid)
  `ALIDS_ASSERT_NOW(a_empty_gives_fail_word, m_valid_q && m_res_q.status == STAT_EMPTY, m_res_q.data_out == FAIL_WORD && m_res_q.count == '0)
  `ALIDS_ASSERT_NOW(a_full_has_words, m_valid_q && m_res_q.status == STAT_FULL, m_res_q.count != '0)

endmodule

`default_nettype wire

FILE: rtl/alids_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module alids_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/alids_cmp.sv
// Signed compare and min/max unit shared by all sort passes.
// Depends on alids_pkg.
`default_nettype none

module alids_cmp (
  input  wire logic [alids_pkg::VAL_W-1:0] a_i,
  input  wire logic [alids_pkg::VAL_W-1:0] b_i,
  output logic                             gt_o,
  output logic      [alids_pkg::VAL_W-1:0] lo_o,
  output logic      [alids_pkg::VAL_W-1:0] hi_o
);

  import alids_pkg::*;

  assign gt_o = $signed(a_i) > $signed(b_i);
  assign lo_o = gt_o ? b_i : a_i;
  assign hi_o = gt_o ? a_i : b_i;

endmodule

`default_nettype wire

FILE: rtl/alids_ctrl.sv
// Sequencer of the packed list unit: decode, shift, bubble sort and clearing pass.
// Depends on alids_pkg and alids_cmp; drives the ports of one alids_ram.
`default_nettype none

module alids_ctrl #(
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [alids_pkg::CAP_W-1:0]      cfg_wdata_i,
  input  wire logic                             item_valid_i,
  input  wire alids_pkg::alids_item_t           item_i,
  output logic                                  item_ready_o,
  input  wire logic                             out_free_i,
  output logic                                  res_valid_o,
  output alids_pkg::alids_res_t                 res_o,
  output logic                                  ram_we_o,
  output logic      [AW-1:0]                    ram_waddr_o,
  output logic      [alids_pkg::VAL_W-1:0]      ram_wdata_o,
  output logic      [AW-1:0]                    ram_raddr_o,
  input  wire logic [alids_pkg::VAL_W-1:0]      ram_rdata_i
);

  import alids_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (CW > CAP_W) ? CW : CAP_W;

  alids_state_e     state_q, state_d;
  logic [CAP_W-1:0] cap_q, cap_d;
  logic [CW-1:0]    held_q, held_d;
  logic [AW-1:0]    rptr_q, rptr_d;
  logic             more_q, more_d;
  logic             pend_q, pend_d;
  logic             rfirst_q, rfirst_d;
  logic             pfirst_q, pfirst_d;

  logic             dir_q, dir_d;
  logic [AW-1:0]    rend_q, rend_d;
  logic [AW-1:0]    wptr_q, wptr_d;
  logic [AW-1:0]    at_q, at_d;
  logic [AW-1:0]    lim_q, lim_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [VAL_W-1:0] carry_q, carry_d;
  logic             swapped_q, swapped_d;
  logic [VAL_W-1:0] res_data_q, res_data_d;
  alids_status_e    res_status_q, res_status_d;

  logic [KW-1:0]    cap_k, held_k, pos_k;
  logic [AW-1:0]    last_a;
  logic             is_full, is_empty, pos_ge_held, pos_ge_cap;

  alids_state_e     dec_state;
  alids_status_e    dec_status;
  logic [VAL_W-1:0] dec_data;
  logic [AW-1:0]    dec_at;
  logic             dec_up, dec_we, dec_inc, dec_dec;

  logic             cmp_gt;
  logic [VAL_W-1:0] cmp_lo, cmp_hi;

  alids_cmp u_cmp (
    .a_i  (carry_q),
    .b_i  (ram_rdata_i),
    .gt_o (cmp_gt),
    .lo_o (cmp_lo),
    .hi_o (cmp_hi)
  );

  always_comb begin
    if (cap_q == '0) begin
      cap_k = KW'(1);
    end else if (KW'(cap_q) > KW'(DEPTH)) begin
      cap_k = KW'(DEPTH);
    end else begin
      cap_k = KW'(cap_q);
    end
  end

  assign held_k      = KW'(held_q);
  assign pos_k       = KW'(item_i.position);
  assign last_a      = AW'(held_q - CW'(1));
  assign is_full     = held_k >= cap_k;
  assign is_empty    = held_q == '0;
  assign pos_ge_held = pos_k >= held_k;
  assign pos_ge_cap  = pos_k >= cap_k;

  always_comb begin
    dec_state  = ST_DONE;
    dec_status = STAT_OK;
    dec_data   = '0;
    dec_at     = AW'(item_i.position);
    dec_up     = 1'b0;
    dec_we     = 1'b0;
    dec_inc    = 1'b0;
    dec_dec    = 1'b0;
    case (item_i.func)
      FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS: begin
        if (is_full) begin
          dec_status = STAT_FULL;
        end else if (item_i.func == FN_INS_POS && pos_ge_held) begin
          dec_status = STAT_BADPOS;
        end else begin
          dec_inc = 1'b1;
          dec_up  = 1'b1;
          if (item_i.func == FN_INS_HEAD) begin
            dec_at = '0;
          end else if (item_i.func == FN_INS_TAIL) begin
            dec_at = AW'(held_q);
          end
          if (item_i.func == FN_INS_TAIL || is_empty) begin
            dec_we = 1'b1;
          end else begin
            dec_state = ST_SHIFT;
          end
        end
      end
      FN_DEL_HEAD, FN_DEL_TAIL, FN_DEL_POS: begin
        if (is_empty) begin
          dec_status = STAT_EMPTY;
          dec_data   = FAIL_WORD;
        end else if (item_i.func == FN_DEL_POS && pos_ge_held) begin
          dec_status = STAT_BADPOS;
          dec_data   = FAIL_WORD;
        end else begin
          dec_dec   = 1'b1;
          dec_state = ST_SHIFT;
          if (item_i.func == FN_DEL_HEAD) begin
            dec_at = '0;
          end else if (item_i.func == FN_DEL_TAIL) begin
            dec_at = last_a;
          end
        end
      end
      FN_RD_IDX, FN_WR_IDX: begin
        if (pos_ge_cap) begin
          dec_status = STAT_BADPOS;
        end else begin
          dec_inc = pos_ge_held;
          if (item_i.func == FN_WR_IDX) begin
            dec_we = 1'b1;
          end else begin
            dec_state = ST_READ;
          end
        end
      end
      FN_SORT: begin
        if (held_q > CW'(1)) begin
          dec_state = ST_SORT_START;
        end
      end
      default: begin
        dec_state = ST_DONE;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (rptr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid_i) begin
          state_d = dec_state;
        end
      end
      ST_READ: begin
        state_d = ST_DONE;
      end
      ST_SHIFT: begin
        if (!more_q && pend_q) begin
          state_d = dir_q ? ST_SHIFT_END : ST_DONE;
        end
      end
      ST_SHIFT_END: begin
        state_d = ST_DONE;
      end
      ST_SORT_START: begin
        state_d = ST_SORT_RUN;
      end
      ST_SORT_RUN: begin
        if (!more_q && !pend_q) begin
          state_d = (swapped_q && lim_q > AW'(1)) ? ST_SORT_START : ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cap_d        = cfg_we_i ? cfg_wdata_i : cap_q;
    held_d       = held_q;
    rptr_d       = rptr_q;
    more_d       = more_q;
    pend_d       = pend_q;
    rfirst_d     = rfirst_q;
    pfirst_d     = pfirst_q;
    dir_d        = dir_q;
    rend_d       = rend_q;
    wptr_d       = wptr_q;
    at_d         = at_q;
    lim_d        = lim_q;
    val_d        = val_q;
    carry_d      = carry_q;
    swapped_d    = swapped_q;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;
    ram_we_o     = 1'b0;
    ram_waddr_o  = wptr_q;
    ram_wdata_o  = '0;
    ram_raddr_o  = AW'(item_i.position);
    case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = rptr_q;
        rptr_d      = rptr_q + AW'(1);
      end
      ST_IDLE: begin
        if (item_valid_i) begin
          if (dec_inc) begin
            held_d = held_q + CW'(1);
          end else if (dec_dec) begin
            held_d = held_q - CW'(1);
          end
          res_data_d   = dec_data;
          res_status_d = dec_status;
          val_d        = item_i.value;
          at_d         = dec_at;
          dir_d        = dec_up;
          rptr_d       = dec_up ? last_a : dec_at;
          rend_d       = dec_up ? dec_at : last_a;
          lim_d        = last_a;
          more_d       = 1'b1;
          pend_d       = 1'b0;
          rfirst_d     = !dec_up;
          ram_we_o     = dec_we;
          ram_waddr_o  = dec_at;
          ram_wdata_o  = item_i.value;
        end
      end
      ST_READ: begin
        res_data_d = ram_rdata_i;
      end
      ST_SHIFT: begin
        if (pend_q) begin
          if (pfirst_q) begin
            res_data_d = ram_rdata_i;
          end else begin
            ram_we_o    = 1'b1;
            ram_waddr_o = wptr_q;
            ram_wdata_o = ram_rdata_i;
          end
        end
        if (more_q) begin
          ram_raddr_o = rptr_q;
          pend_d      = 1'b1;
          pfirst_d    = rfirst_q;
          rfirst_d    = 1'b0;
          wptr_d      = dir_q ? rptr_q + AW'(1) : rptr_q - AW'(1);
          rptr_d      = dir_q ? rptr_q - AW'(1) : rptr_q + AW'(1);
          more_d      = rptr_q != rend_q;
        end else begin
          pend_d = 1'b0;
        end
      end
      ST_SHIFT_END: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = at_q;
        ram_wdata_o = val_q;
      end
      ST_SORT_START: begin
        ram_raddr_o = '0;
        rptr_d      = AW'(1);
        more_d      = 1'b1;
        pend_d      = 1'b1;
        pfirst_d    = 1'b1;
        swapped_d   = 1'b0;
      end
      ST_SORT_RUN: begin
        if (pend_q) begin
          if (pfirst_q) begin
            carry_d = ram_rdata_i;
          end else begin
            ram_we_o    = 1'b1;
            ram_waddr_o = wptr_q;
            ram_wdata_o = cmp_lo;
            carry_d     = cmp_hi;
            if (cmp_gt) begin
              swapped_d = 1'b1;
            end
          end
        end
        if (more_q) begin
          ram_raddr_o = rptr_q;
          pend_d      = 1'b1;
          pfirst_d    = 1'b0;
          wptr_d      = rptr_q - AW'(1);
          rptr_d      = rptr_q + AW'(1);
          more_d      = rptr_q != lim_q;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = lim_q;
            ram_wdata_o = carry_q;
            lim_d       = lim_q - AW'(1);
          end
        end
      end
      ST_DONE: begin
        ram_we_o = 1'b0;
      end
      default: begin
        ram_we_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      cap_q    <= CAP_RESET;
      held_q   <= '0;
      rptr_q   <= '0;
      more_q   <= 1'b0;
      pend_q   <= 1'b0;
      rfirst_q <= 1'b0;
      pfirst_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cap_q    <= cap_d;
      held_q   <= held_d;
      rptr_q   <= rptr_d;
      more_q   <= more_d;
      pend_q   <= pend_d;
      rfirst_q <= rfirst_d;
      pfirst_q <= pfirst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q        <= dir_d;
    rend_q       <= rend_d;
    wptr_q       <= wptr_d;
    at_q         <= at_d;
    lim_q        <= lim_d;
    val_q        <= val_d;
    carry_q      <= carry_d;
    swapped_q    <= swapped_d;
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
  end

  assign item_ready_o    = state_q == ST_IDLE;
  assign res_valid_o     = state_q == ST_DONE;
  assign res_o.data_out  = res_data_q;
  assign res_o.status    = res_status_q;
  assign res_o.count     = CNT_W'(held_q);

endmodule

`default_nettype wire
